/* design/bc_pkg.sv */
// ----------------------------------------------------------------------------
// bc_pkg
// shared types and register codes of the barometer compensation block
// ----------------------------------------------------------------------------
package bc_pkg;

	typedef struct packed {
		logic        opcode;
		logic [15:0] raw_temp;
		logic [15:0] raw_pressure;
	} bc_cmd_t;

	typedef struct packed {
		logic signed [15:0] temperature;
		logic        [15:0] pressure;
		logic               has_pressure;
		logic               divide_fault;
	} bc_res_t;

	typedef struct packed {
		logic [31:0] ac1_ac2;
		logic [31:0] ac3_ac4;
		logic [31:0] ac5_ac6;
		logic [31:0] b1_b2;
		logic [31:0] mc_md;
		logic [7:0]  offset;
	} bc_coef_t;

	typedef struct packed {
		logic        valid;
		bc_cmd_t     item;
	} bc_queue_t;

	typedef enum logic [2:0] {
		REG_AC1_AC2  = 3'd0,
		REG_AC3_AC4  = 3'd1,
		REG_AC5_AC6  = 3'd2,
		REG_B1_B2    = 3'd3,
		REG_MC_MD    = 3'd4,
		REG_P_OFFSET = 3'd5
	} bc_reg_t;

	localparam int AddrWidth = 5;

endpackage

/* design/bc_front.sv */
// ----------------------------------------------------------------------------
// bc_front
// accepts commands and holds them in a two-entry queue for the back end
// ----------------------------------------------------------------------------
module bc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  bc_pkg::bc_cmd_t   cmd,
	output logic              busy,
	output bc_pkg::bc_queue_t head,
	input  logic              pop
);

	bc_pkg::bc_cmd_t mem_q [2];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      cnt_q;
	logic            push;

	assign busy      = (cnt_q == 2'd2);
	assign push      = start && !busy;
	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* design/bc_div.sv */
// ----------------------------------------------------------------------------
// bc_div
// unsigned 32 by 32 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] quo
);

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [32:0] sh;
	logic [32:0] diff;
	logic        ge;

	assign sh   = {rem_q, quo_q[31]};
	assign diff = sh - {1'b0, den_q};
	assign ge   = (sh >= {1'b0, den_q});
	assign done = done_q;
	assign quo  = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? diff[31:0] : sh[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == 5'd31);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					run_q <= 1'b0;
				end
			end
		end
	end

endmodule

/* design/bc_back.sv */
// ----------------------------------------------------------------------------
// bc_back
// compensation sequencer with one shared multiplier and a shared divider
// ----------------------------------------------------------------------------
module bc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  bc_pkg::bc_coef_t  coef,
	input  bc_pkg::bc_queue_t head,
	output logic              pop,
	output logic              done,
	output bc_pkg::bc_res_t   result
);

	typedef enum logic [22:0] {
		ST_IDLE = 23'd1 << 0,
		ST_T0   = 23'd1 << 1,
		ST_T1   = 23'd1 << 2,
		ST_TDIV = 23'd1 << 3,
		ST_TB   = 23'd1 << 4,
		ST_P1   = 23'd1 << 5,
		ST_P2   = 23'd1 << 6,
		ST_P3   = 23'd1 << 7,
		ST_P4   = 23'd1 << 8,
		ST_P5   = 23'd1 << 9,
		ST_P6   = 23'd1 << 10,
		ST_P7   = 23'd1 << 11,
		ST_P8   = 23'd1 << 12,
		ST_P9   = 23'd1 << 13,
		ST_P10  = 23'd1 << 14,
		ST_PDIV = 23'd1 << 15,
		ST_P11  = 23'd1 << 16,
		ST_P12  = 23'd1 << 17,
		ST_P13  = 23'd1 << 18,
		ST_P14  = 23'd1 << 19,
		ST_P15  = 23'd1 << 20,
		ST_P16  = 23'd1 << 21,
		ST_P17  = 23'd1 << 22
	} state_t;

	localparam logic [31:0] Recip10 = 32'hCCCCCCCD;

	function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
		return 32'($signed(v) >>> s);
	endfunction

	function automatic logic [31:0] sx(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] mag(input logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	state_t          st_q;
	bc_pkg::bc_cmd_t item_q;
	bc_pkg::bc_res_t res_q;
	logic            valid_q;
	logic [31:0]     x1_q, b5_q, b6_q, sq_q, t1_q, t2_q, b3_q, b4_q, b7_q, p_q, mag_q;
	logic [28:0]     q10_q;
	logic [15:0]     temp_q;
	logic            sign_q;

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	logic [31:0] mul_a, mul_b, lo, den, sum, n4, n5, q10;
	logic [63:0] prod;
	logic [15:0] off10;
	logic        div_start, div_done;
	logic [31:0] div_num, div_den, div_quo;

	assign ac1 = sx(coef.ac1_ac2[31:16]);
	assign ac2 = sx(coef.ac1_ac2[15:0]);
	assign ac3 = sx(coef.ac3_ac4[31:16]);
	assign ac4 = {16'd0, coef.ac3_ac4[15:0]};
	assign ac5 = {16'd0, coef.ac5_ac6[31:16]};
	assign ac6 = {16'd0, coef.ac5_ac6[15:0]};
	assign b1  = sx(coef.b1_b2[31:16]);
	assign b2  = sx(coef.b1_b2[15:0]);
	assign mc  = sx(coef.mc_md[31:16]);
	assign md  = sx(coef.mc_md[15:0]);

	assign den   = x1_q + md;
	assign n4    = (ac1 << 2) + t1_q + t2_q + 32'd2;
	assign n5    = p_q + 32'd5;
	assign q10   = {3'd0, q10_q};
	assign off10 = 16'({{8{coef.offset[7]}}, coef.offset} * 16'd10);
	assign prod  = {32'd0, mul_a} * {32'd0, mul_b};
	assign lo    = prod[31:0];
	assign pop   = (st_q == ST_IDLE) && head.valid;
	assign done  = valid_q;
	assign result = res_q;

	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = mag(mc << 11);
		div_den   = mag(den);
		sum       = '0;
		unique case (st_q)
			ST_T0: begin
				mul_a = {16'd0, item_q.raw_temp} - ac6;
				mul_b = ac5;
			end
			ST_T1: begin
				div_start = (den != 32'd0);
			end
			ST_P1: begin
				mul_a = b6_q;
				mul_b = b6_q;
			end
			ST_P2: begin
				mul_a = b2;
				mul_b = sq_q;
			end
			ST_P3: begin
				mul_a = ac2;
				mul_b = b6_q;
			end
			ST_P5: begin
				mul_a = ac3;
				mul_b = b6_q;
			end
			ST_P6: begin
				mul_a = b1;
				mul_b = sq_q;
			end
			ST_P8: begin
				mul_a = ac4;
				mul_b = t1_q + 32'd32768;
			end
			ST_P9: begin
				mul_a = {16'd0, item_q.raw_pressure} - b3_q;
				mul_b = 32'd50000;
			end
			ST_P10: begin
				div_start = 1'b1;
				div_num   = b7_q[31] ? b7_q : (b7_q << 1);
				div_den   = b4_q;
			end
			ST_P11: begin
				mul_a = asr(p_q, 5'd8);
				mul_b = asr(p_q, 5'd8);
			end
			ST_P12: begin
				mul_a = t1_q;
				mul_b = 32'd3038;
			end
			ST_P13: begin
				mul_a = 32'd0 - 32'd7357;
				mul_b = p_q;
			end
			ST_P14: begin
				sum = t1_q + t2_q + 32'd3791;
			end
			ST_P16: begin
				mul_a = mag_q;
				mul_b = Recip10;
			end
			default: begin
			end
		endcase
	end

	bc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: if (head.valid) begin
				item_q <= head.item;
			end
			ST_T0:   x1_q <= asr(lo, 5'd15);
			ST_T1:   sign_q <= mc[31] ^ den[31];
			ST_TDIV: if (div_done) begin
				b5_q <= x1_q + (sign_q ? (32'd0 - div_quo) : div_quo);
			end
			ST_TB: begin
				temp_q <= 16'(asr(b5_q + 32'd8, 5'd4));
				b6_q   <= b5_q - 32'd4000;
			end
			ST_P1:   sq_q <= asr(lo, 5'd12);
			ST_P2:   t1_q <= asr(lo, 5'd11);
			ST_P3:   t2_q <= asr(lo, 5'd11);
			ST_P4:   b3_q <= asr(n4 + (n4[31] ? 32'd3 : 32'd0), 5'd2);
			ST_P5:   t1_q <= asr(lo, 5'd13);
			ST_P6:   t2_q <= asr(lo, 5'd16);
			ST_P7:   t1_q <= asr(t1_q + t2_q + 32'd2, 5'd2);
			ST_P8:   b4_q <= lo >> 15;
			ST_P9:   b7_q <= lo;
			ST_P10:  sign_q <= b7_q[31];
			ST_PDIV: if (div_done) begin
				p_q <= sign_q ? (div_quo << 1) : div_quo;
			end
			ST_P11:  t1_q <= lo;
			ST_P12:  t1_q <= asr(lo, 5'd16);
			ST_P13:  t2_q <= asr(lo, 5'd16);
			ST_P14:  p_q <= p_q + asr(sum, 5'd4);
			ST_P15: begin
				sign_q <= n5[31];
				mag_q  <= mag(n5);
			end
			ST_P16:  q10_q <= prod[63:35];
			ST_P17: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_T1 && den == 32'd0) begin
			res_q <= '{temperature: '0, pressure: '0, has_pressure: 1'b0, divide_fault: 1'b1};
		end else if (st_q == ST_TB && !item_q.opcode) begin
			res_q <= '{temperature: 16'(asr(b5_q + 32'd8, 5'd4)), pressure: '0,
				has_pressure: 1'b0, divide_fault: 1'b0};
		end else if (st_q == ST_P9 && b4_q == 32'd0) begin
			res_q <= '{temperature: '0, pressure: '0, has_pressure: 1'b0, divide_fault: 1'b1};
		end else if (st_q == ST_P17) begin
			res_q <= '{temperature: temp_q,
				pressure: 16'(sign_q ? (32'd0 - q10) : q10) + off10,
				has_pressure: 1'b1, divide_fault: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (head.valid) begin
					st_q <= ST_T0;
				end
				ST_T0: st_q <= ST_T1;
				ST_T1: begin
					if (den == 32'd0) begin
						valid_q <= 1'b1;
						st_q    <= ST_IDLE;
					end else begin
						st_q <= ST_TDIV;
					end
				end
				ST_TDIV: if (div_done) begin
					st_q <= ST_TB;
				end
				ST_TB: begin
					if (!item_q.opcode) begin
						valid_q <= 1'b1;
						st_q    <= ST_IDLE;
					end else begin
						st_q <= ST_P1;
					end
				end
				ST_P1: st_q <= ST_P2;
				ST_P2: st_q <= ST_P3;
				ST_P3: st_q <= ST_P4;
				ST_P4: st_q <= ST_P5;
				ST_P5: st_q <= ST_P6;
				ST_P6: st_q <= ST_P7;
				ST_P7: st_q <= ST_P8;
				ST_P8: st_q <= ST_P9;
				ST_P9: begin
					if (b4_q == 32'd0) begin
						valid_q <= 1'b1;
						st_q    <= ST_IDLE;
					end else begin
						st_q <= ST_P10;
					end
				end
				ST_P10: st_q <= ST_PDIV;
				ST_PDIV: if (div_done) begin
					st_q <= ST_P11;
				end
				ST_P11: st_q <= ST_P12;
				ST_P12: st_q <= ST_P13;
				ST_P13: st_q <= ST_P14;
				ST_P14: st_q <= ST_P15;
				ST_P15: st_q <= ST_P16;
				ST_P16: st_q <= ST_P17;
				ST_P17: begin
					valid_q <= 1'b1;
					st_q    <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* design/barometer_compensation.sv */
// ----------------------------------------------------------------------------
// barometer_compensation
// integer temperature and pressure compensation of a barometric sensor
// ----------------------------------------------------------------------------
// channel   signals                               transaction when
// command   start, busy, cmd                      start && !busy
// result    done, result                          done (one cycle, no stall)
// config    psel, penable, pwrite, paddr, pwdata  psel && penable && pwrite
//
// a temperature-only command waits on the divider at most once, a pressure
// command at most twice; these divider waits and the shared multiplier set how
// long the sequencer is held. a two-entry command queue takes new commands while
// one is in work; busy rises only when the queue is full. reset clears queue,
// sequencer and calibration registers.
// ----------------------------------------------------------------------------
module barometer_compensation (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  bc_pkg::bc_cmd_t                cmd,
	output logic                           busy,
	output logic                           done,
	output bc_pkg::bc_res_t                result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bc_pkg::AddrWidth-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	bc_pkg::bc_coef_t  coef_q;
	bc_pkg::bc_queue_t head;
	logic              pop;
	logic              wr_en;
	bc_pkg::bc_reg_t   idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = bc_pkg::bc_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				bc_pkg::REG_AC1_AC2:  coef_q.ac1_ac2 <= pwdata;
				bc_pkg::REG_AC3_AC4:  coef_q.ac3_ac4 <= pwdata;
				bc_pkg::REG_AC5_AC6:  coef_q.ac5_ac6 <= pwdata;
				bc_pkg::REG_B1_B2:    coef_q.b1_b2   <= pwdata;
				bc_pkg::REG_MC_MD:    coef_q.mc_md   <= pwdata;
				bc_pkg::REG_P_OFFSET: coef_q.offset  <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			bc_pkg::REG_AC1_AC2:  prdata = coef_q.ac1_ac2;
			bc_pkg::REG_AC3_AC4:  prdata = coef_q.ac3_ac4;
			bc_pkg::REG_AC5_AC6:  prdata = coef_q.ac5_ac6;
			bc_pkg::REG_B1_B2:    prdata = coef_q.b1_b2;
			bc_pkg::REG_MC_MD:    prdata = coef_q.mc_md;
			bc_pkg::REG_P_OFFSET: prdata = {24'd0, coef_q.offset};
			default:              prdata = '0;
		endcase
	end

	bc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.head   (head),
		.pop    (pop)
	);

	bc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.coef   (coef_q),
		.head   (head),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule

/* design/bc_checker.sv */
// ----------------------------------------------------------------------------
// bc_checker
// port-level checks of the compensation block, bound to the top level
// ----------------------------------------------------------------------------
module bc_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            done,
	input bc_pkg::bc_res_t result
);

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held two cycles");

	a_no_pres_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.has_pressure |-> result.pressure == 16'd0)
		else $error("pressure nonzero without pressure flag");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.divide_fault |-> result.temperature == 16'sd0 && !result.has_pressure)
		else $error("fault result not cleared");

endmodule

bind barometer_compensation bc_checker u_bc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.done   (done),
	.result (result)
);

/* tb/sv/tb_barometer_compensation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_barometer_compensation
// drives compensation commands through a random-gap command driver, programs
// calibration sets over the register port between phases, and checks every
// result strobe against an integer compensation predictor kept in the bench
// ----------------------------------------------------------------------------
module tb_barometer_compensation;

	localparam int LIMIT = 20000;
	localparam int DRAIN = 200;

	logic clk;
	logic arst_n;
	logic start;
	bc_pkg::bc_cmd_t cmd;
	logic busy;
	logic done;
	bc_pkg::bc_res_t result;
	logic psel, penable, pwrite;
	logic [bc_pkg::AddrWidth-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	barometer_compensation dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	bc_pkg::bc_coef_t cal;
	bc_pkg::bc_cmd_t pending_cmds[$];
	bc_pkg::bc_res_t expected_results[$];
	int mismatches;
	int idle_cycles;
	int gap;
	bit feed_on;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [31:0] sra(logic [31:0] v, int s);
		return $unsigned($signed(v) >>> s);
	endfunction

	function automatic logic [31:0] div_trunc(logic [31:0] n, logic [31:0] d);
		logic [31:0] an, ad, q;
		an = n[31] ? -n : n;
		ad = d[31] ? -d : d;
		q = an / ad;
		return (n[31] != d[31]) ? -q : q;
	endfunction

	function automatic logic [31:0] sext(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic bc_pkg::bc_res_t compensate(bc_pkg::bc_cmd_t c);
		bc_pkg::bc_res_t r;
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [31:0] x1, x2, x3, b5, b6, b3, b4, b7, p, sq, den, pr;
		ac1 = sext(cal.ac1_ac2[31:16]);
		ac2 = sext(cal.ac1_ac2[15:0]);
		ac3 = sext(cal.ac3_ac4[31:16]);
		ac4 = {16'd0, cal.ac3_ac4[15:0]};
		ac5 = {16'd0, cal.ac5_ac6[31:16]};
		ac6 = {16'd0, cal.ac5_ac6[15:0]};
		b1 = sext(cal.b1_b2[31:16]);
		b2 = sext(cal.b1_b2[15:0]);
		mc = sext(cal.mc_md[31:16]);
		md = sext(cal.mc_md[15:0]);
		r = '0;
		x1 = sra(({16'd0, c.raw_temp} - ac6) * ac5, 15);
		den = x1 + md;
		if (den == 0) begin
			r.divide_fault = 1'b1;
			return r;
		end
		x2 = div_trunc(mc * 32'd2048, den);
		b5 = x1 + x2;
		r.temperature = 16'(sra(b5 + 32'd8, 4));
		if (!c.opcode) return r;
		b6 = b5 - 32'd4000;
		sq = sra(b6 * b6, 12);
		x1 = sra(b2 * sq, 11);
		x2 = sra(ac2 * b6, 11);
		x3 = x1 + x2;
		b3 = div_trunc(ac1 * 32'd4 + x3 + 32'd2, 32'd4);
		x1 = sra(ac3 * b6, 13);
		x2 = sra(b1 * sq, 16);
		x3 = sra(x1 + x2 + 32'd2, 2);
		b4 = (ac4 * (x3 + 32'd32768)) >> 15;
		if (b4 == 0) begin
			r = '0;
			r.divide_fault = 1'b1;
			return r;
		end
		b7 = ({16'd0, c.raw_pressure} - b3) * 32'd50000;
		p = !b7[31] ? (b7 * 32'd2) / b4 : (b7 / b4) * 32'd2;
		x1 = sra(p, 8) * sra(p, 8);
		x1 = sra(x1 * 32'd3038, 16);
		x2 = sra(-32'd7357 * p, 16);
		p = p + sra(x1 + x2 + 32'd3791, 4);
		pr = div_trunc(p + 32'd5, 32'd10) + {{24{cal.offset[7]}}, cal.offset} * 32'd10;
		r.pressure = pr[15:0];
		r.has_pressure = 1'b1;
		return r;
	endfunction

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			gap <= 0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(compensate(cmd));
			end
			if (start && busy) begin
			end else if (gap > 0) begin
				start <= 1'b0;
				gap <= gap - 1;
			end else if (feed_on && pending_cmds.size() > 0) begin
				start <= 1'b1;
				cmd <= pending_cmds.pop_front();
				if ($urandom_range(0, 3) == 0)
					gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
						: $urandom_range(1, 4);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", result);
			end else begin
				bc_pkg::bc_res_t e;
				e = expected_results.pop_front();
				if (result.temperature !== e.temperature ||
						result.pressure !== e.pressure ||
						result.has_pressure !== e.has_pressure ||
						result.divide_fault !== e.divide_fault) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %p got %p", e, result);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done || psel) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(bc_pkg::bc_reg_t r, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= bc_pkg::AddrWidth'(r) << 2;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			bc_pkg::REG_AC1_AC2: cal.ac1_ac2 = v;
			bc_pkg::REG_AC3_AC4: cal.ac3_ac4 = v;
			bc_pkg::REG_AC5_AC6: cal.ac5_ac6 = v;
			bc_pkg::REG_B1_B2: cal.b1_b2 = v;
			bc_pkg::REG_MC_MD: cal.mc_md = v;
			bc_pkg::REG_P_OFFSET: cal.offset = v[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_cal(logic [31:0] a, logic [31:0] b, logic [31:0] c,
			logic [31:0] d, logic [31:0] e, logic [7:0] off);
		write_reg(bc_pkg::REG_AC1_AC2, a);
		write_reg(bc_pkg::REG_AC3_AC4, b);
		write_reg(bc_pkg::REG_AC5_AC6, c);
		write_reg(bc_pkg::REG_B1_B2, d);
		write_reg(bc_pkg::REG_MC_MD, e);
		write_reg(bc_pkg::REG_P_OFFSET, {24'd0, off});
	endtask

	task automatic run_phase(int n);
		bc_pkg::bc_cmd_t c;
		for (int i = 0; i < n; i++) begin
			c.opcode = ($urandom_range(0, 3) != 0);
			c.raw_temp = ($urandom_range(0, 1)) ? 16'($urandom_range(20000, 35000))
				: 16'($urandom);
			c.raw_pressure = ($urandom_range(0, 1)) ? 16'($urandom_range(20000, 45000))
				: 16'($urandom);
			pending_cmds.push_back(c);
		end
		feed_on = 1'b1;
		wait (pending_cmds.size() == 0);
		@(posedge clk);
		while (start) @(posedge clk);
		feed_on = 1'b0;
		while (expected_results.size() > 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic push(logic op, logic [15:0] t, logic [15:0] p);
		bc_pkg::bc_cmd_t c;
		c.opcode = op;
		c.raw_temp = t;
		c.raw_pressure = p;
		pending_cmds.push_back(c);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cal = '0;
		feed_on = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset calibration: all divisors zero
		push(1'b0, 16'd0, 16'd0);
		push(1'b1, 16'hFFFF, 16'hFFFF);
		run_phase(0);

		// typical datasheet calibration
		load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
			{16'd32757, 16'd23153}, {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 8'd0);
		push(1'b1, 16'd27898, 16'd23843);
		push(1'b0, 16'd27898, 16'd23843);
		push(1'b1, 16'd0, 16'd0);
		push(1'b1, 16'hFFFF, 16'hFFFF);
		push(1'b1, 16'h8000, 16'h0001);
		push(1'b0, 16'hFFFF, 16'h0000);
		run_phase(150);

		// offsets at the extremes, temperature divisor made zero at ut == ac6
		load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
			{16'd32757, 16'd23153}, {16'd6190, 16'd4}, {-16'sd8711, 16'd0}, 8'h7F);
		push(1'b1, 16'd23153, 16'd30000);
		push(1'b0, 16'd23153, 16'd30000);
		run_phase(150);
		write_reg(bc_pkg::REG_P_OFFSET, 32'h80);
		run_phase(100);

		// ac4 zero gives a pressure divide fault; most-negative mc over -1
		load_cal(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_8000,
			32'h8000_FFFF, 8'hFF);
		push(1'b1, 16'd0, 16'd0);
		push(1'b0, 16'hFFFF, 16'hFFFF);
		run_phase(50);

		load_cal($urandom, $urandom, $urandom, $urandom, $urandom, 8'($urandom));
		run_phase(75);
		load_cal(32'h7FFF_7FFF, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h7FFF_7FFF,
			32'h7FFF_7FFF, 8'd0);
		run_phase(75);

		if (mismatches == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule
